// ===== sv/sth_pkg.sv =====
// Package for the string tuple hash block: constants, sequencer and multiplier
// state types, and the request and response structs of the shared multiplier.
// No dependencies.
package sth_pkg;

	localparam int unsigned WORD_W       = 64;
	localparam int unsigned HALF_W       = 32;
	localparam int unsigned REM_W        = 5;
	localparam int unsigned LENGTH_WIDTH = 16;
	localparam int unsigned SEED_SHIFT   = 7;

	localparam logic [REM_W-1:0]        MAX_STRINGS = REM_W'(16);
	localparam logic [LENGTH_WIDTH-1:0] COUNT_MAX   = '1;

	localparam logic [WORD_W-1:0] STR_MULT   = 64'd1000003;
	localparam logic [WORD_W-1:0] TUPLE_SEED = 64'h0000_0000_0034_5678;
	localparam logic [WORD_W-1:0] MULT_SEED  = 64'd1000003;
	localparam logic [WORD_W-1:0] MULT_STEP  = 64'd82520;
	localparam logic [WORD_W-1:0] TUPLE_ADD  = 64'd97531;
	localparam logic [WORD_W-1:0] MINUS_ONE  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] MINUS_TWO  = 64'hFFFF_FFFF_FFFF_FFFE;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STR_MUL,
		ST_FOLD_MUL,
		ST_EMIT
	} sth_state_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_LL,
		MP_HL,
		MP_LH,
		MP_SUM
	} sth_mul_ph_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} sth_mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] product;
	} sth_mul_rsp_t;

endpackage

// ===== sv/sth_if.sv =====
// Channel interfaces of the string tuple hash block: the byte input channel
// and the hash result channel, each with valid, ready and payload.
// No dependencies.
interface sth_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       empty_string;
	logic       string_end;
	logic       list_end;
	logic [4:0] string_count;

	modport source (
		output valid, data_byte, empty_string, string_end, list_end, string_count,
		input  ready
	);
	modport sink (
		input  valid, data_byte, empty_string, string_end, list_end, string_count,
		output ready
	);
endinterface

interface sth_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] tuple_hash;
	logic        [31:0] digest;

	modport source (
		output valid, tuple_hash, digest,
		input  ready
	);
	modport sink (
		input  valid, tuple_hash, digest,
		output ready
	);
endinterface

// ===== sv/sth_mul.sv =====
// Shared 64 by 64 bit multiplier that keeps the low 64 bits of the product.
// It runs one 32 by 32 bit multiplier over three partial products.
// Depends on sth_pkg.
module sth_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sth_pkg::sth_mul_req_t req,
	output sth_pkg::sth_mul_rsp_t rsp
);
	import sth_pkg::*;

	sth_mul_ph_t         ph_q;
	sth_mul_ph_t         ph_d;
	logic                done_q;
	logic [WORD_W-1:0]   a_q;
	logic [WORD_W-1:0]   b_q;
	logic [WORD_W-1:0]   prod_q;
	logic [WORD_W-1:0]   res_q;
	logic [HALF_W-1:0]   op_a;
	logic [HALF_W-1:0]   op_b;
	logic [WORD_W-1:0]   prod_d;

	always_comb begin
		op_a = a_q[HALF_W-1:0];
		op_b = b_q[HALF_W-1:0];
		case (ph_q)
			MP_HL: op_a = a_q[WORD_W-1:HALF_W];
			MP_LH: op_b = b_q[WORD_W-1:HALF_W];
			default: ;
		endcase
	end

	assign prod_d = WORD_W'(op_a) * WORD_W'(op_b);

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			MP_IDLE: if (req.start) ph_d = MP_LL;
			MP_LL:   ph_d = MP_HL;
			MP_HL:   ph_d = MP_LH;
			MP_LH:   ph_d = MP_SUM;
			MP_SUM:  ph_d = MP_IDLE;
			default: ph_d = MP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= MP_IDLE;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			done_q <= (ph_q == MP_SUM);
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == MP_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_q <= prod_d;
		case (ph_q)
			MP_HL: res_q <= prod_q;
			MP_LH, MP_SUM: res_q[WORD_W-1:HALF_W] <= res_q[WORD_W-1:HALF_W] +
				prod_q[HALF_W-1:0];
			default: ;
		endcase
	end

	assign rsp.done    = done_q;
	assign rsp.product = res_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (ph_q == MP_IDLE))
		else $error("multiplier start outside idle");
	a_done_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ph_q) == MP_SUM)
		else $error("multiplier done without final pass");
	a_pass_order: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == MP_LL) |=> (ph_q == MP_HL))
		else $error("multiplier passes out of order");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == MP_HL) |=> (ph_q == MP_LH) ##1 (ph_q == MP_SUM) ##1 done_q)
		else $error("multiplier sequence broken");
`endif

endmodule

// ===== sv/string_tuple_hash.sv =====
// Top level of the string tuple hash block: sequencer, hash state and result
// register around the shared multiplier. Depends on sth_pkg, sth_if, sth_mul.
//
//   channel    role  payload
//   str_chan   sink  data_byte, empty_string, string_end, list_end, string_count
//   hash_chan  src   tuple_hash, digest
//
// A byte runs one string multiply; a byte that ends a string also runs the fold
// multiply, and one that ends the list then emits; an empty string item skips the
// string multiply. Each product is built from three partial products and a sum.
// arst_n clears all hash state to its start values. A pending result waits in
// the output register; a list end stalls only while that register is full.
module string_tuple_hash (
	input  logic clk,
	input  logic arst_n,
	sth_in_if.sink    str_chan,
	sth_out_if.source hash_chan
);
	import sth_pkg::*;

	sth_state_t              state_q;
	sth_state_t              state_d;
	sth_mul_req_t            mul_req;
	sth_mul_rsp_t            mul_rsp;

	logic [WORD_W-1:0]       string_acc_q;
	logic [LENGTH_WIDTH-1:0] count_q;
	logic                    at_string_start_q;
	logic [WORD_W-1:0]       tuple_acc_q;
	logic [WORD_W-1:0]       multiplier_q;
	logic [REM_W-1:0]        remaining_q;
	logic                    at_list_start_q;
	logic [7:0]              byte_q;
	logic                    send_q;
	logic                    lend_q;
	logic                    out_valid_q;
	logic [WORD_W-1:0]       out_hash_q;
	logic [HALF_W-1:0]       out_digest_q;

	logic                    accept;
	logic                    out_free;
	logic [WORD_W-1:0]       tacc_eff;
	logic [WORD_W-1:0]       mult_eff;
	logic [REM_W-1:0]        rem_clamp;
	logic [REM_W-1:0]        rem_eff;
	logic [REM_W-1:0]        rem_eff_dec;
	logic [REM_W-1:0]        rem_dec;
	logic [WORD_W-1:0]       str_seed;
	logic [LENGTH_WIDTH-1:0] count_base;
	logic [WORD_W-1:0]       sacc_new;
	logic [WORD_W-1:0]       str_hash;
	logic [WORD_W-1:0]       str_hash_fix;
	logic [WORD_W-1:0]       fin_sum;
	logic [WORD_W-1:0]       fin_hash;
	logic [HALF_W-1:0]       fin_digest;

	assign accept   = str_chan.valid && str_chan.ready;
	assign out_free = !out_valid_q || hash_chan.ready;

	assign tacc_eff    = at_list_start_q ? TUPLE_SEED : tuple_acc_q;
	assign mult_eff    = at_list_start_q ? MULT_SEED : multiplier_q;
	assign rem_clamp   = (str_chan.string_count > MAX_STRINGS) ? MAX_STRINGS :
		str_chan.string_count;
	assign rem_eff     = at_list_start_q ? rem_clamp : remaining_q;
	assign rem_eff_dec = (rem_eff != '0) ? rem_eff - REM_W'(1) : '0;
	assign rem_dec     = (remaining_q != '0) ? remaining_q - REM_W'(1) : '0;

	assign str_seed   = at_string_start_q ? (WORD_W'(str_chan.data_byte) << SEED_SHIFT) :
		string_acc_q;
	assign count_base = at_string_start_q ? '0 : count_q;

	assign sacc_new     = mul_rsp.product ^ WORD_W'(byte_q);
	assign str_hash     = sacc_new ^ WORD_W'(count_q);
	assign str_hash_fix = (str_hash == MINUS_ONE) ? MINUS_TWO : str_hash;

	assign fin_sum    = tuple_acc_q + TUPLE_ADD;
	assign fin_hash   = (fin_sum == MINUS_ONE) ? MINUS_TWO : fin_sum;
	assign fin_digest = fin_hash[WORD_W-1] ? (~fin_hash[HALF_W-1:0] + HALF_W'(1)) :
		fin_hash[HALF_W-1:0];

	sth_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_comb begin
		state_d        = state_q;
		str_chan.ready = 1'b0;
		mul_req.start  = 1'b0;
		mul_req.a      = str_seed;
		mul_req.b      = STR_MULT;
		case (state_q)
			ST_IDLE: begin
				str_chan.ready = 1'b1;
				if (str_chan.valid) begin
					mul_req.start = 1'b1;
					if (str_chan.empty_string) begin
						mul_req.a = tacc_eff;
						mul_req.b = mult_eff;
						state_d   = ST_FOLD_MUL;
					end else begin
						state_d = ST_STR_MUL;
					end
				end
			end
			ST_STR_MUL: begin
				mul_req.a = tuple_acc_q ^ str_hash_fix;
				mul_req.b = multiplier_q;
				if (mul_rsp.done) begin
					if (send_q) begin
						mul_req.start = 1'b1;
						state_d       = ST_FOLD_MUL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FOLD_MUL: begin
				if (mul_rsp.done) state_d = lend_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			out_valid_q       <= 1'b0;
			string_acc_q      <= '0;
			count_q           <= '0;
			at_string_start_q <= 1'b1;
			tuple_acc_q       <= TUPLE_SEED;
			multiplier_q      <= MULT_SEED;
			remaining_q       <= '0;
			at_list_start_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (hash_chan.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						at_list_start_q <= 1'b0;
						tuple_acc_q     <= tacc_eff;
						multiplier_q    <= mult_eff;
						if (str_chan.empty_string) begin
							string_acc_q      <= '0;
							count_q           <= '0;
							at_string_start_q <= 1'b1;
							remaining_q       <= rem_eff_dec;
						end else begin
							remaining_q       <= rem_eff;
							at_string_start_q <= 1'b0;
							count_q           <= (count_base == COUNT_MAX) ? COUNT_MAX :
								count_base + LENGTH_WIDTH'(1);
						end
					end
				end
				ST_STR_MUL: begin
					if (mul_rsp.done) begin
						string_acc_q <= sacc_new;
						if (send_q) begin
							remaining_q       <= rem_dec;
							at_string_start_q <= 1'b1;
						end
					end
				end
				ST_FOLD_MUL: begin
					if (mul_rsp.done) begin
						tuple_acc_q  <= mul_rsp.product;
						multiplier_q <= multiplier_q + MULT_STEP +
							WORD_W'({remaining_q, 1'b0});
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						at_list_start_q   <= 1'b1;
						at_string_start_q <= 1'b1;
						tuple_acc_q       <= TUPLE_SEED;
						multiplier_q      <= MULT_SEED;
						remaining_q       <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= str_chan.data_byte;
			send_q <= str_chan.string_end || str_chan.list_end;
			lend_q <= str_chan.list_end;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_hash_q   <= fin_hash;
			out_digest_q <= fin_digest;
		end
	end

	assign hash_chan.valid      = out_valid_q;
	assign hash_chan.tuple_hash = out_hash_q;
	assign hash_chan.digest     = out_digest_q;

`ifndef ASSERT_OFF
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_STR_MUL || state_q == ST_FOLD_MUL))
		else $error("multiplier result with no waiting state");
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result transaction raised outside emit");
	a_list_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD_MUL && mul_rsp.done && lend_q) |=> state_q == ST_EMIT)
		else $error("list end did not reach emit");
	a_remaining_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= MAX_STRINGS)
		else $error("remaining string count above bound");
`endif

endmodule

// ===== bench/string_tuple_hash_test.sv =====
// Self-checking testbench for string_tuple_hash: streams lists of Latin-1 strings
// through the byte channel and checks every tuple hash and digest against a
// built-in predictor. Depends on sth_pkg, sth_if and the string_tuple_hash RTL.
`timescale 1ns / 1ps

module string_tuple_hash_test;
	import sth_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned PHASE_ITEMS = 200;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       empty_string;
		logic       string_end;
		logic       list_end;
		logic [4:0] string_count;
		logic [6:0] gap_pct;
		logic [6:0] stall_pct;
		logic       wait_drain;
	} byte_item_t;

	typedef struct packed {
		logic [63:0] tuple_hash;
		logic [31:0] digest;
	} hash_result_t;

	logic clk;
	logic arst_n;

	sth_in_if  str_chan ();
	sth_out_if hash_chan ();

	string_tuple_hash uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.str_chan  (str_chan),
		.hash_chan (hash_chan)
	);

	byte_item_t   byte_stream[$];
	hash_result_t pending_hashes[$];
	byte_item_t   offered;
	bit           in_flight = 0;
	int unsigned  stall_pct = 0;
	int unsigned  mismatches = 0;
	int unsigned  phase_count = 0;

	logic [WORD_W-1:0]       str_acc;
	logic [LENGTH_WIDTH-1:0] byte_cnt;
	logic                    str_start;
	logic [WORD_W-1:0]       tup_acc;
	logic [WORD_W-1:0]       tup_mult;
	logic [REM_W-1:0]        strings_left;
	logic                    list_start;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic fold_string_hash(input logic [WORD_W-1:0] h);
		if (strings_left != '0) strings_left = strings_left - REM_W'(1);
		tup_acc = (tup_acc ^ h) * tup_mult;
		tup_mult = tup_mult + MULT_STEP + WORD_W'(strings_left) + WORD_W'(strings_left);
	endtask

	task automatic absorb_byte(input byte_item_t it);
		logic [WORD_W-1:0] h;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] mag;
		hash_result_t      res;
		if (list_start) begin
			strings_left = (it.string_count > MAX_STRINGS) ? MAX_STRINGS : it.string_count;
			tup_acc = TUPLE_SEED;
			tup_mult = MULT_SEED;
			list_start = 1'b0;
		end
		if (it.empty_string) begin
			str_acc = '0;
			byte_cnt = '0;
			str_start = 1'b1;
			fold_string_hash('0);
		end else begin
			if (str_start) begin
				str_acc = WORD_W'(it.data_byte) << SEED_SHIFT;
				byte_cnt = '0;
				str_start = 1'b0;
			end
			str_acc = (str_acc * STR_MULT) ^ WORD_W'(it.data_byte);
			if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + LENGTH_WIDTH'(1);
			if (it.string_end || it.list_end) begin
				h = str_acc ^ WORD_W'(byte_cnt);
				if (h == MINUS_ONE) h = MINUS_TWO;
				fold_string_hash(h);
				str_start = 1'b1;
			end
		end
		if (it.list_end) begin
			x = tup_acc + TUPLE_ADD;
			if (x == MINUS_ONE) x = MINUS_TWO;
			mag = x[63] ? -x : x;
			res.tuple_hash = x;
			res.digest = mag[31:0];
			pending_hashes.push_back(res);
			list_start = 1'b1;
			str_start = 1'b1;
			tup_acc = TUPLE_SEED;
			tup_mult = MULT_SEED;
			strings_left = '0;
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic e, input logic s, input logic l,
			input logic [4:0] c, input int unsigned gap, input int unsigned stall,
			input bit drain);
		byte_item_t it;
		it.data_byte = b;
		it.empty_string = e;
		it.string_end = s;
		it.list_end = l;
		it.string_count = c;
		it.gap_pct = 7'(gap);
		it.stall_pct = 7'(stall);
		it.wait_drain = drain;
		byte_stream.push_back(it);
		phase_count++;
	endtask

	// Mostly well-formed lists with random content; some announce a wrong
	// string count, and some drop a partial string through an empty item.
	task automatic add_random_list(input int unsigned gap, input int unsigned stall,
			input bit drain);
		int unsigned n_str;
		int unsigned len;
		int unsigned kind;
		bit          last;
		bit          first;
		logic [4:0]  cnt;
		first = 1'b1;
		n_str = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		cnt = ($urandom_range(4) == 0) ? 5'($urandom_range(1, 31)) : 5'(n_str > 31 ? 31 : n_str);
		for (int unsigned k = 0; k < n_str; k++) begin
			last = (k == n_str - 1);
			kind = $urandom_range(19);
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			if (kind == 1) begin
				for (int unsigned j = 0; j < len; j++) begin
					add_item(8'($urandom), 1'b0, 1'b0, 1'b0,
						first ? cnt : 5'($urandom_range(1, 31)), gap, stall, drain && first);
					first = 1'b0;
				end
			end
			if (kind <= 1) begin
				add_item(8'($urandom), 1'b1, 1'($urandom), last,
					first ? cnt : 5'($urandom_range(1, 31)), gap, stall, drain && first);
				first = 1'b0;
			end else begin
				for (int unsigned j = 0; j < len; j++) begin
					add_item(8'($urandom), 1'b0,
						(j == len - 1) ? (last ? 1'($urandom) : 1'b1) : 1'b0,
						last && (j == len - 1),
						first ? cnt : 5'($urandom_range(1, 31)), gap, stall, drain && first);
					first = 1'b0;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && !in_flight && byte_stream.size() != 0
				&& !(byte_stream[0].wait_drain && pending_hashes.size() != 0)
				&& $urandom_range(99) >= byte_stream[0].gap_pct) begin
			offered = byte_stream.pop_front();
			stall_pct = offered.stall_pct;
			in_flight = 1'b1;
			str_chan.valid <= 1'b1;
			str_chan.data_byte <= offered.data_byte;
			str_chan.empty_string <= offered.empty_string;
			str_chan.string_end <= offered.string_end;
			str_chan.list_end <= offered.list_end;
			str_chan.string_count <= offered.string_count;
		end else if (!in_flight) begin
			str_chan.valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (in_flight && str_chan.valid === 1'b1 && str_chan.ready === 1'b1) begin
			absorb_byte(offered);
			in_flight = 1'b0;
		end
	end

	always @(negedge clk) begin
		hash_chan.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		hash_result_t want;
		if (arst_n && hash_chan.valid === 1'b1 && hash_chan.ready === 1'b1) begin
			if (pending_hashes.size() == 0) begin
				$display("%0t: unexpected result, tuple_hash %h digest %h", $time,
					hash_chan.tuple_hash, hash_chan.digest);
				mismatches++;
			end else begin
				want = pending_hashes.pop_front();
				if (hash_chan.tuple_hash !== want.tuple_hash) begin
					$display("%0t: tuple_hash expected %h, actual %h", $time,
						want.tuple_hash, hash_chan.tuple_hash);
					mismatches++;
				end
				if (hash_chan.digest !== want.digest) begin
					$display("%0t: digest expected %h, actual %h", $time,
						want.digest, hash_chan.digest);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		str_chan.valid = 1'b0;
		str_chan.data_byte = '0;
		str_chan.empty_string = 1'b0;
		str_chan.string_end = 1'b0;
		str_chan.list_end = 1'b0;
		str_chan.string_count = '0;
		hash_chan.ready = 1'b0;
		str_acc = '0;
		byte_cnt = '0;
		str_start = 1'b1;
		tup_acc = TUPLE_SEED;
		tup_mult = MULT_SEED;
		strings_left = '0;
		list_start = 1'b1;

		// Single bytes at both extremes, the second with the largest legal count.
		add_item(8'h00, 1'b0, 1'b1, 1'b1, 5'd1, 0, 0, 1'b0);
		add_item(8'hFF, 1'b0, 1'b1, 1'b1, 5'd16, 0, 0, 1'b0);
		// A count above the bound is clamped.
		add_item(8'h61, 1'b0, 1'b1, 1'b0, 5'd31, 0, 0, 1'b0);
		add_item(8'h62, 1'b0, 1'b0, 1'b0, 5'd0, 0, 0, 1'b0);
		add_item(8'h63, 1'b0, 1'b1, 1'b0, 5'd0, 0, 0, 1'b0);
		add_item(8'h64, 1'b0, 1'b1, 1'b1, 5'd0, 0, 0, 1'b0);
		// More strings than announced drive the remaining count to zero.
		add_item(8'h80, 1'b0, 1'b1, 1'b0, 5'd1, 0, 0, 1'b0);
		add_item(8'h00, 1'b1, 1'b1, 1'b0, 5'd31, 0, 0, 1'b0);
		add_item(8'h7F, 1'b0, 1'b1, 1'b1, 5'd31, 0, 0, 1'b0);
		// A list made of one empty string, with its ignored byte set.
		add_item(8'hFF, 1'b1, 1'b1, 1'b1, 5'd2, 0, 0, 1'b0);
		// An empty item drops a partial string; the list then ends without a string end.
		add_item(8'h78, 1'b0, 1'b0, 1'b0, 5'd2, 0, 0, 1'b0);
		add_item(8'h79, 1'b0, 1'b0, 1'b0, 5'd2, 0, 0, 1'b0);
		add_item(8'h00, 1'b1, 1'b0, 1'b0, 5'd2, 0, 0, 1'b0);
		add_item(8'h7A, 1'b0, 1'b0, 1'b0, 5'd2, 0, 0, 1'b0);
		add_item(8'h55, 1'b0, 1'b0, 1'b1, 5'd2, 0, 0, 1'b0);

		phase_count = 0;
		while (phase_count < PHASE_ITEMS) add_random_list(0, 0, phase_count == 0);
		phase_count = 0;
		while (phase_count < PHASE_ITEMS) add_random_list(53, 0, phase_count == 0);
		phase_count = 0;
		while (phase_count < PHASE_ITEMS) add_random_list(0, 53, phase_count == 0);
		phase_count = 0;
		while (phase_count < PHASE_ITEMS) add_random_list(14, 14, phase_count == 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_stream.size() != 0 || in_flight || pending_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_hashes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== string_tuple_hash.f =====
sv/sth_pkg.sv
sv/sth_if.sv
sv/sth_mul.sv
sv/string_tuple_hash.sv
bench/string_tuple_hash_test.sv
